@@ src/european_call_binomial_price_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the binomial call pricer checks
// ----------------------------------------------------------------------------
`ifndef EUROPEAN_CALL_BINOMIAL_PRICE_ASSERT_SVH
`define EUROPEAN_CALL_BINOMIAL_PRICE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define ECBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define ECBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ecbp_pkg.sv @@
// ----------------------------------------------------------------------------
// ecbp_pkg
// Shared widths, constants and types of the binomial call pricer.
// ----------------------------------------------------------------------------
package ecbp_pkg;

  localparam int PRICE_W    = 40;
  localparam int RATE_W     = 32;
  localparam int STEPS_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;
  localparam int DIV_W      = 72;   // dividend / quotient width of the divider
  localparam int ACC_W      = 74;   // MAC accumulator width

  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
  localparam logic [RATE_W-1:0]  Q30_ONE   = 32'h4000_0000;

  // register reset values
  localparam logic [PRICE_W-1:0] SPOT_RST = 40'd6553600;
  localparam logic [RATE_W-1:0]  UP_RST   = 32'd53687091;
  localparam logic [RATE_W-1:0]  DOWN_RST = 32'hFCCC_CCCD;   // -53687091
  localparam logic [RATE_W-1:0]  RATE_RST = 32'd10737418;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPOT = 2'd0,
    CFG_UP   = 2'd1,
    CFG_DOWN = 2'd2,
    CFG_RATE = 2'd3
  } cfg_idx_e;

  // one MAC job: x0*y0 (+ x1*y1 when two is set), Q30 rounded
  typedef struct packed {
    logic [PRICE_W-1:0] x0;
    logic [RATE_W-1:0]  y0;
    logic [PRICE_W-1:0] x1;
    logic [RATE_W-1:0]  y1;
    logic               two;
  } mac_req_t;

endpackage

@@ src/ecbp_if.sv @@
// ----------------------------------------------------------------------------
// ecbp channel interfaces
// Valid/ready channels for the request, result and register-write words.
// ----------------------------------------------------------------------------
interface ecbp_in_if import ecbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STEPS_W-1:0] steps;
  logic [PRICE_W-1:0] strike;

  modport source (output valid, steps, strike, input ready);
  modport sink   (input valid, steps, strike, output ready);
endinterface

interface ecbp_out_if import ecbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  logic               invalid;

  modport source (output valid, price, invalid, input ready);
  modport sink   (input valid, price, invalid, output ready);
endinterface

interface ecbp_cfg_if import ecbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/ecbp_mac.sv @@
// ----------------------------------------------------------------------------
// ecbp_mac
// Multi-cycle Q30 multiply-accumulate: one 20x32 partial product a cycle,
// round half up, saturate to the price range.
// ----------------------------------------------------------------------------
module ecbp_mac import ecbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mac_req_t           req_i,
  output logic               done_o,
  output logic [PRICE_W-1:0] res_o
);

  logic               busy_q, pv_q, plast_q, fin_q, done_q, psh_q;
  logic [1:0]         cnt_q;
  mac_req_t           req_q;
  logic [51:0]        pp_q;
  logic [ACC_W-1:0]   acc_q;
  logic [PRICE_W-1:0] res_q;

  logic [PRICE_W-1:0] xs;
  logic [RATE_W-1:0]  ys;
  logic [19:0]        xh;
  logic               last;
  logic [ACC_W-1:0]   rsum;
  logic [43:0]        rs;

  // operand select: bit1 picks the term, bit0 the half of x
  always_comb begin
    xs   = cnt_q[1] ? req_q.x1 : req_q.x0;
    ys   = cnt_q[1] ? req_q.y1 : req_q.y0;
    xh   = cnt_q[0] ? xs[39:20] : xs[19:0];
    last = req_q.two ? (cnt_q == 2'd3) : (cnt_q == 2'd1);
    rsum = acc_q + (ACC_W'(1) << 29);
    rs   = rsum[73:30];
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      plast_q <= 1'b0;
      fin_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 2'd1;
        end
      end
      pv_q    <= busy_q;
      plast_q <= busy_q && last;
      fin_q   <= plast_q;
      done_q  <= fin_q;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
    end
    if (busy_q) begin
      pp_q  <= {32'b0, xh} * {20'b0, ys};
      psh_q <= cnt_q[0];
    end
    if (start_i) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + (psh_q ? {2'b0, pp_q, 20'b0} : {22'b0, pp_q});
    end
    if (fin_q) begin
      res_q <= (|rs[43:40]) ? PRICE_MAX : rs[39:0];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ src/ecbp_div.sv @@
// ----------------------------------------------------------------------------
// ecbp_div
// Restoring divider, one quotient bit a cycle, full-width quotient.
// ----------------------------------------------------------------------------
module ecbp_div import ecbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [RATE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quo_o
);

  logic              busy_q, done_q;
  logic [6:0]        cnt_q;
  logic [DIV_W-1:0]  sh_q;
  logic [RATE_W-1:0] rem_q, dvs_q;

  logic [RATE_W:0]   shifted, diff;
  logic              ge;

  always_comb begin
    shifted = {rem_q, sh_q[DIV_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 7'(DIV_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 7'(DIV_W - 1)) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 7'd1;
        end
      end
    end
  end

  // shift / subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      sh_q  <= {sh_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

@@ src/european_call_binomial_price.sv @@
// ----------------------------------------------------------------------------
// european_call_binomial_price
// Binomial-tree European call pricer with a node memory.
// ----------------------------------------------------------------------------
// Usage:
//  cfg_i writes S0, U, D and R (index 0..3); it is always ready and must be
//  used only while the block is idle.
//  in_i takes one word (steps N, strike K); out_o returns one word (price,
//  invalid flag) for each. in_i is ready only while no item is in work.
//  An invalid request (N or K zero, U <= D) goes straight to the done state.
//  Otherwise, with N clamped to MAX_STEPS, the leaf prices (N multiplies
//  each) and the backward induction (one two-term multiply-accumulate per
//  node) run through one shared MAC, the leaves live in a one-port-read
//  node memory, and q (unless it is 0 or 1) and each of the N discount
//  steps use a serial divider.
//  The result waits in an output register; a new item is taken while it
//  waits, and the next result holds until that register is free.
//  Reset restores the register defaults and empties the pipeline; the node
//  memory needs no clearing since every entry is written before it is read.
// ----------------------------------------------------------------------------
module european_call_binomial_price import ecbp_pkg::*; #(
  parameter int MAX_STEPS = 64
) (
  input logic          clk_i,
  input logic          rst_ni,
  ecbp_cfg_if.sink     cfg_i,
  ecbp_in_if.sink      in_i,
  ecbp_out_if.source   out_o
);

  localparam int AW = $clog2(MAX_STEPS + 1);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_QDIV  = 12'b0000_0000_0010,
    ST_NISS  = 12'b0000_0000_0100,
    ST_NWAIT = 12'b0000_0000_1000,
    ST_LO    = 12'b0000_0001_0000,
    ST_LOW   = 12'b0000_0010_0000,
    ST_HI    = 12'b0000_0100_0000,
    ST_MIX   = 12'b0000_1000_0000,
    ST_MWAIT = 12'b0001_0000_0000,
    ST_DISC  = 12'b0010_0000_0000,
    ST_DWAIT = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_e;

  function automatic logic [RATE_W-1:0] growth(logic [RATE_W-1:0] rate);
    logic signed [RATE_W:0] g;
    g = $signed({rate[RATE_W-1], rate}) + $signed({1'b0, Q30_ONE});
    return g[RATE_W] ? '0 : g[RATE_W-1:0];
  endfunction

  state_e state_q, state_d;

  logic [PRICE_W-1:0]       spot_q;
  logic signed [RATE_W-1:0] up_q, down_q, rate_q;

  logic [AW-1:0]      n_q, i_q, j_q;
  logic [PRICE_W-1:0] k_q, v_q, lo_q, hi_q;
  logic               inv_q;
  logic [RATE_W-1:0]  gu_q, gd_q, gr_q, q_q, p_q;

  logic               out_valid_q, out_invalid_q;
  logic [PRICE_W-1:0] out_price_q;

  logic [PRICE_W-1:0] node_mem_q [MAX_STEPS + 1];
  logic [PRICE_W-1:0] rdata_q;

  // request decode
  logic                     accept, bad, q_zero, q_one;
  logic signed [RATE_W:0]   num, den;
  logic [AW-1:0]            n_clamp;
  logic [RATE_W-1:0]        gr_in;

  // MAC and divider hookup
  logic               mac_start, mac_done;
  mac_req_t           mac_req;
  logic [PRICE_W-1:0] mac_res, payoff;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_quo, div_rnd;
  logic [RATE_W-1:0]  div_divisor;
  logic [PRICE_W-1:0] disc_sat;

  // node memory strobes
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, i_inc;

  // sequencing flags
  logic node_last, node_end, pass_end, out_free;

  always_comb begin
    accept  = in_i.valid && (state_q == ST_IDLE);
    bad     = (in_i.steps == '0) || (in_i.strike == '0) || (up_q <= down_q);
    num     = $signed({rate_q[RATE_W-1], rate_q}) - $signed({down_q[RATE_W-1], down_q});
    den     = $signed({up_q[RATE_W-1], up_q}) - $signed({down_q[RATE_W-1], down_q});
    q_zero  = num <= $signed((RATE_W + 1)'(0));
    q_one   = num >= den;
    n_clamp = (int'(in_i.steps) > MAX_STEPS) ? AW'(MAX_STEPS) : AW'(in_i.steps);
    gr_in   = (growth(rate_q) == '0) ? RATE_W'(1) : growth(rate_q);

    i_inc     = i_q + AW'(1);
    node_last = (j_q + AW'(1)) == n_q;
    node_end  = i_q == n_q;
    pass_end  = i_inc == j_q;
    out_free  = !out_valid_q || out_o.ready;

    payoff   = (mac_res > k_q) ? (mac_res - k_q) : '0;
    div_rnd  = (div_quo + DIV_W'(1)) >> 1;
    disc_sat = (|div_rnd[DIV_W-1:PRICE_W]) ? PRICE_MAX : div_rnd[PRICE_W-1:0];
  end

  // MAC requests: leaf chain multiply or induction mix
  always_comb begin
    mac_start = (state_q == ST_NISS) || (state_q == ST_MIX);
    mac_req   = '0;
    if (state_q == ST_MIX) begin
      mac_req.x0  = rdata_q;
      mac_req.y0  = q_q;
      mac_req.x1  = lo_q;
      mac_req.y1  = p_q;
      mac_req.two = 1'b1;
    end else begin
      mac_req.x0 = v_q;
      mac_req.y0 = (({1'b0, j_q} + {1'b0, i_q}) < {1'b0, n_q}) ? gd_q : gu_q;
    end
  end

  // divider requests: probability q or one discount step
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b0, v_q, 31'b0};
    div_divisor  = gr_q;
    if (state_q == ST_DISC) begin
      div_start = 1'b1;
    end else if (accept && !bad && !q_zero && !q_one) begin
      div_start    = 1'b1;
      div_dividend = {9'b0, num[RATE_W-1:0], 31'b0};
      div_divisor  = den[RATE_W-1:0];
    end
  end

  // node memory access
  always_comb begin
    mem_re    = (state_q == ST_LO) || (state_q == ST_LOW) || (state_q == ST_HI);
    mem_raddr = (state_q == ST_LO) ? '0 : i_inc;
    mem_we    = mac_done && (((state_q == ST_NWAIT) && node_last) || (state_q == ST_MWAIT));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem_q[i_q] <= (state_q == ST_NWAIT) ? payoff : mac_res;
    end
    if (mem_re) begin
      rdata_q <= node_mem_q[mem_raddr];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (bad) begin
            state_d = ST_DONE;
          end else if (q_zero || q_one) begin
            state_d = ST_NISS;
          end else begin
            state_d = ST_QDIV;
          end
        end
      end
      ST_QDIV:  if (div_done) state_d = ST_NISS;
      ST_NISS:  state_d = ST_NWAIT;
      ST_NWAIT: begin
        if (mac_done) begin
          state_d = (node_last && node_end) ? ST_LO : ST_NISS;
        end
      end
      ST_LO:    state_d = ST_LOW;
      ST_LOW:   state_d = ST_MIX;
      ST_HI:    state_d = ST_MIX;
      ST_MIX:   state_d = ST_MWAIT;
      ST_MWAIT: begin
        if (mac_done) begin
          if (pass_end) begin
            state_d = (j_q == AW'(1)) ? ST_DISC : ST_LO;
          end else begin
            state_d = ST_HI;
          end
        end
      end
      ST_DISC:  state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_d = node_last ? ST_DONE : ST_DISC;
        end
      end
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      spot_q      <= SPOT_RST;
      up_q        <= UP_RST;
      down_q      <= DOWN_RST;
      rate_q      <= RATE_RST;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_SPOT: spot_q <= cfg_i.data[PRICE_W-1:0];
          CFG_UP:   up_q   <= cfg_i.data[RATE_W-1:0];
          CFG_DOWN: down_q <= cfg_i.data[RATE_W-1:0];
          CFG_RATE: rate_q <= cfg_i.data[RATE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          n_q   <= n_clamp;
          k_q   <= in_i.strike;
          inv_q <= bad;
          gu_q  <= growth(up_q);
          gd_q  <= growth(down_q);
          gr_q  <= gr_in;
          q_q   <= q_one ? Q30_ONE : '0;
          p_q   <= q_one ? '0 : Q30_ONE;
          v_q   <= spot_q;
          i_q   <= '0;
          j_q   <= '0;
        end
      end
      ST_QDIV: begin
        if (div_done) begin
          q_q <= div_rnd[RATE_W-1:0];
          p_q <= Q30_ONE - div_rnd[RATE_W-1:0];
        end
      end
      ST_NWAIT: begin
        if (mac_done) begin
          if (node_last) begin
            v_q <= spot_q;
            if (node_end) begin
              i_q <= '0;
              j_q <= n_q;
            end else begin
              i_q <= i_inc;
              j_q <= '0;
            end
          end else begin
            v_q <= mac_res;
            j_q <= j_q + AW'(1);
          end
        end
      end
      ST_LOW: lo_q <= rdata_q;
      ST_MIX: hi_q <= rdata_q;
      ST_MWAIT: begin
        if (mac_done) begin
          if (pass_end) begin
            i_q <= '0;
            if (j_q == AW'(1)) begin
              v_q <= mac_res;
              j_q <= '0;
            end else begin
              j_q <= j_q - AW'(1);
            end
          end else begin
            lo_q <= hi_q;
            i_q  <= i_inc;
          end
        end
      end
      ST_DWAIT: begin
        if (div_done) begin
          v_q <= disc_sat;
          j_q <= j_q + AW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_price_q   <= inv_q ? '0 : v_q;
          out_invalid_q <= inv_q;
        end
      end
      default: ;
    endcase
  end

  ecbp_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .req_i   (mac_req),
    .done_o  (mac_done),
    .res_o   (mac_res)
  );

  ecbp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign cfg_i.ready   = 1'b1;
  assign in_i.ready    = (state_q == ST_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.price   = out_price_q;
  assign out_o.invalid = out_invalid_q;

endmodule

@@ src/ecbp_chk.sv @@
// ----------------------------------------------------------------------------
// ecbp_chk
// Port-level checks of the binomial call pricer, bound to the top level.
// ----------------------------------------------------------------------------
`include "european_call_binomial_price_assert.svh"

module ecbp_chk import ecbp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [PRICE_W-1:0] out_price_i,
  input logic               out_invalid_i
);

  // a rejected request always reports a zero price
  `ECBP_ASSERT_NOW(a_inv_zero, out_valid_i && out_invalid_i, out_price_i == '0, "invalid with nonzero price")

  // one item in work at a time: request side closes right after a take
  `ECBP_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i, "second item taken while busy")

  // stalled result word stays put
  `ECBP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_price_i) && $stable(out_invalid_i), "stalled result changed")

endmodule

bind european_call_binomial_price ecbp_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_price_i   (out_o.price),
  .out_invalid_i (out_o.invalid)
);
